/* rtl/dapq_pkg.sv */
package dapq_pkg;

   // request codes
   localparam logic [1:0] REQ_INSERT  = 2'd0;
   localparam logic [1:0] REQ_EXTRACT = 2'd1;
   localparam logic [1:0] REQ_INCKEY  = 2'd2;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   localparam int KEY_W = 32;
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

   // sequencer states, one-hot
   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_UPRD   = 10'b0000000010,
      S_UPCMP  = 10'b0000000100,
      S_DNRD   = 10'b0000001000,
      S_DNCMP  = 10'b0000010000,
      S_DNSWP  = 10'b0000100000,
      S_UPSWP  = 10'b0001000000,
      S_EXRD   = 10'b0010000000,
      S_EXWR   = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

endpackage

/* rtl/dapq_ram.sv */
module dapq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/d_ary_max_priority_queue.sv */
// d-ary max-heap priority queue. Pulse start with req_type/key/position while busy is
// low; one result appears on the rsp_ ports for a single cycle marked by rsp_valid and
// the receiver cannot stall it. Every heap access goes through one memory with a
// registered read port. A request climbs the heap by writing the current slot, reading
// the parent and comparing, or descends by writing, then reading and comparing each
// child in turn and moving the larger one up, then passes through a done state;
// rsp_valid rises as busy falls. Failed and unknown requests go straight to done.
// Slot p of the heap lives at memory address p - 1.
module d_ary_max_priority_queue #(
   parameter int CAPACITY  = 64,
   parameter int MAX_ARITY = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_type,
   input  logic signed [dapq_pkg::KEY_W-1:0] req_key,
   input  logic [6:0]                      req_position,
   input  logic                            csr_wr_en,
   input  logic [2:0]                      csr_arity,
   output logic                            rsp_valid,
   output logic signed [dapq_pkg::KEY_W-1:0] rsp_max_key,
   output logic [1:0]                      rsp_status,
   output logic [6:0]                      rsp_count
);
   import dapq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1) + 1;  // slot index, room for overshoot
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = $clog2(MAX_ARITY + 1);
   localparam int RS = PW + 4;                    // reciprocal shift

   state_type state_ff, state_in;
   logic [2:0]          arity_ff, arity_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [PW-1:0]       pos_ff, pos_in;      // current slot
   logic [PW-1:0]       oth_ff, oth_in;      // parent, best child or last slot
   logic [PW-1:0]       chd_ff, chd_in;      // child being scanned
   logic [DW-1:0]       k_ff, k_in;          // children left to scan
   logic signed [KEY_W-1:0] cur_ff, cur_in;  // value at pos
   logic signed [KEY_W-1:0] best_ff, best_in;
   logic signed [KEY_W-1:0] maxk_ff, maxk_in;
   logic [1:0]          stat_ff, stat_in;
   logic [1:0]          stm_ff, stm_in;      // 0 read issued, 1 data back, 2 second word back
   logic                valid_ff, valid_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [KEY_W-1:0] wr_data, rd_data;

   logic [DW-1:0] d_eff;
   logic [PW-1:0] parent;
   logic [PW-1:0] par_q [2:MAX_ARITY];
   logic [PW+DW:0] child0;

   dapq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // saturated arity
   always_comb begin
      if (arity_ff < 3'd2) begin
         d_eff = DW'(2);
      end else if (32'(arity_ff) > MAX_ARITY) begin
         d_eff = DW'(MAX_ARITY);
      end else begin
         d_eff = DW'(arity_ff);
      end
   end

   // parent of pos for each arity: (pos-2)/d+1 by reciprocal multiplication
   for (genvar g = 2; g <= MAX_ARITY; g++) begin : g_par
      localparam int RCP = ((1 << RS) + g - 1) / g;
      logic [PW+RS:0] prod;
      assign prod     = (PW+RS+1)'(pos_ff - PW'(2)) * (PW+RS+1)'(RCP);
      assign par_q[g] = PW'(prod >> RS) + PW'(1);
   end

   // pick the parent for the current arity
   always_comb begin
      parent = '0;
      for (int i = 2; i <= MAX_ARITY; i++) begin
         if (32'(d_eff) == i) begin
            parent = par_q[i];
         end
      end
   end

   // first child of pos: d*(pos-1)+2
   assign child0 = (PW+DW+1)'(d_eff) * (PW+DW+1)'(pos_ff - PW'(1)) + (PW+DW+1)'(2);

   // sequencer
   always_comb begin
      state_in = state_ff;
      arity_in = arity_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      oth_in   = oth_ff;
      chd_in   = chd_ff;
      k_in     = k_ff;
      cur_in   = cur_ff;
      best_in  = best_ff;
      maxk_in  = maxk_ff;
      stat_in  = stat_ff;
      stm_in   = stm_ff;
      valid_in = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = AW'(pos_ff - PW'(1));
      wr_data  = cur_ff;
      rd_addr  = AW'(pos_ff - PW'(1));

      if (csr_wr_en) begin
         arity_in = csr_arity;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               maxk_in = '0;
               stat_in = ST_OK;
               case (req_type)
                  REQ_INSERT: begin
                     if (32'(count_ff) >= CAPACITY) begin
                        stat_in  = ST_FULL;
                        state_in = S_DONE;
                     end else begin
                        // sentinel raised to key is just the key
                        count_in = count_ff + CW'(1);
                        pos_in   = PW'(count_ff) + PW'(1);
                        cur_in   = req_key;
                        state_in = S_UPSWP;
                     end
                  end
                  REQ_EXTRACT: begin
                     if (count_ff == '0) begin
                        stat_in  = ST_EMPTY;
                        state_in = S_DONE;
                     end else begin
                        pos_in   = PW'(1);
                        oth_in   = PW'(count_ff);
                        state_in = S_EXRD;
                        stm_in   = 2'd0;
                     end
                  end
                  REQ_INCKEY: begin
                     if (req_position == '0 || 32'(req_position) > 32'(count_ff)) begin
                        stat_in  = ST_BADPOS;
                        state_in = S_DONE;
                     end else begin
                        pos_in   = PW'(req_position);
                        cur_in   = req_key;
                        state_in = S_UPRD;
                        stm_in   = 2'd0;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // increase key: read slot, keep the larger
         S_UPRD: begin
            if (stm_ff == 2'd0) begin
               stm_in = 2'd1;
            end else begin
               if ($signed(rd_data) > cur_ff) begin
                  cur_in = $signed(rd_data);
               end
               state_in = S_UPSWP;
            end
         end
         // write cur at pos, then look at parent
         S_UPSWP: begin
            wr_en = 1'b1;
            if (pos_ff <= PW'(1)) begin
               state_in = S_DONE;
            end else begin
               oth_in   = parent;
               state_in = S_UPCMP;
               stm_in   = 2'd0;
            end
         end
         S_UPCMP: begin
            rd_addr = AW'(oth_ff - PW'(1));
            if (stm_ff == 2'd0) begin
               stm_in = 2'd1;
            end else if ($signed(rd_data) < cur_ff) begin
               // move parent down, carry on from parent slot
               wr_en    = 1'b1;
               wr_data  = rd_data;
               pos_in   = oth_ff;
               state_in = S_UPSWP;
            end else begin
               state_in = S_DONE;
            end
         end
         // extract: read root and last entry
         S_EXRD: begin
            case (stm_ff)
               2'd0: begin
                  stm_in = 2'd1;
               end
               2'd1: begin
                  maxk_in = $signed(rd_data);
                  rd_addr = AW'(oth_ff - PW'(1));
                  stm_in  = 2'd2;
               end
               default: begin
                  cur_in   = $signed(rd_data);
                  count_in = count_ff - CW'(1);
                  state_in = S_EXWR;
               end
            endcase
         end
         S_EXWR: begin
            wr_en    = 1'b1;
            state_in = S_DNRD;
         end
         // start scanning children of pos
         S_DNRD: begin
            if (child0 > (PW+DW+1)'(count_ff)) begin
               state_in = S_DONE;
            end else begin
               chd_in   = PW'(child0);
               oth_in   = pos_ff;
               best_in  = cur_ff;
               k_in     = d_eff;
               stm_in   = 2'd0;
               state_in = S_DNCMP;
            end
         end
         // one child per step: read it, then compare with the best so far
         S_DNCMP: begin
            rd_addr = AW'(chd_ff - PW'(1));
            if (stm_ff == 2'd0) begin
               stm_in = 2'd1;
            end else begin
               if (best_ff < $signed(rd_data)) begin
                  best_in = $signed(rd_data);
                  oth_in  = chd_ff;
               end
               if (k_ff == DW'(1) || chd_ff >= PW'(count_ff)) begin
                  state_in = S_DNSWP;
               end else begin
                  chd_in = chd_ff + PW'(1);
                  k_in   = k_ff - DW'(1);
                  stm_in = 2'd0;
               end
            end
         end
         S_DNSWP: begin
            if (oth_ff == pos_ff) begin
               state_in = S_DONE;
            end else begin
               // larger child up, cur moves to child slot
               wr_en    = 1'b1;
               wr_data  = best_ff;
               pos_in   = oth_ff;
               state_in = S_EXWR;
            end
         end
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         arity_ff <= 3'd2;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         arity_ff <= arity_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      pos_ff  <= pos_in;
      oth_ff  <= oth_in;
      chd_ff  <= chd_in;
      k_ff    <= k_in;
      cur_ff  <= cur_in;
      best_ff <= best_in;
      maxk_ff <= maxk_in;
      stat_ff <= stat_in;
      stm_ff  <= stm_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = valid_ff;
   assign rsp_max_key = maxk_ff;
   assign rsp_status  = stat_ff;
   assign rsp_count   = 7'(count_ff);

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY) else $error("count overflow");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE)) else $error("stray response");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with response");
   a_maxk_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_max_key == '0)
      else $error("max key on failure");
endmodule

/* test/d_ary_max_priority_queue_tb.sv */
`timescale 1ns / 1ps

module d_ary_max_priority_queue_tb;
   import dapq_pkg::*;

   localparam int DEPTH     = 64;
   localparam int ARITY_TOP = 4;
   localparam int SETTLE    = 40;

   typedef enum int {E_REQ, E_ARITY, E_DRAIN, E_GAPS} entry_kind_type;

   typedef struct {
      entry_kind_type    kind;
      logic [1:0]        rtype;
      logic signed [31:0] key;
      logic [6:0]        pos;
      int                val;
   } entry_type;

   typedef struct {
      logic signed [31:0] max_key;
      logic [1:0]         status;
      logic [6:0]         count;
   } outcome_type;

   logic clock = 0, reset = 1;
   logic start = 0, csr_wr_en = 0;
   logic [1:0] req_type = REQ_INSERT;
   logic signed [31:0] req_key = '0;
   logic [6:0] req_position = '0;
   logic [2:0] csr_arity = 3'd2;
   logic busy, rsp_valid;
   logic signed [31:0] rsp_max_key;
   logic [1:0] rsp_status;
   logic [6:0] rsp_count;

   entry_type   stimulus[$];
   outcome_type pending_outcomes[$];
   int  issued = 0, taken = 0, gap_pct = 0, settle_cnt = 0, gen_count = 0;
   bit  failed = 0, stim_done = 0;

   // shadow heap
   logic signed [31:0] heap_mem[1:DEPTH];
   int  shadow_count = 0;
   logic [2:0] arity_reg = 3'd2;

   d_ary_max_priority_queue uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_key(req_key), .req_position(req_position),
      .csr_wr_en(csr_wr_en), .csr_arity(csr_arity),
      .rsp_valid(rsp_valid), .rsp_max_key(rsp_max_key),
      .rsp_status(rsp_status), .rsp_count(rsp_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int fanout();
      if (arity_reg < 2) return 2;
      if (arity_reg > ARITY_TOP) return ARITY_TOP;
      return arity_reg;
   endfunction

   function automatic void heap_swap(int a, int b);
      logic signed [31:0] t;
      t = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
   endfunction

   function automatic void raise_slot(int p, logic signed [31:0] k, int d);
      int par;
      if (heap_mem[p] < k) heap_mem[p] = k;
      while (p > 1) begin
         par = (p - 2) / d + 1;
         if (!(heap_mem[par] < heap_mem[p])) break;
         heap_swap(par, p);
         p = par;
      end
   endfunction

   function automatic void sink_root(int d);
      int p, big, c;
      p = 1;
      forever begin
         big = p;
         for (int k = 1; k <= d; k++) begin
            c = d * (p - 1) + k + 1;
            if (c > shadow_count) break;
            if (heap_mem[big] < heap_mem[c]) big = c;
         end
         if (big == p) break;
         heap_swap(p, big);
         p = big;
      end
   endfunction

   // expected outcome of one request; updates the shadow heap
   function automatic outcome_type heap_request(logic [1:0] rt, logic signed [31:0] k,
                                                logic [6:0] pos);
      outcome_type o;
      int d;
      d = fanout();
      o.max_key = '0;
      o.status  = ST_OK;
      case (rt)
         REQ_INSERT: begin
            if (shadow_count >= DEPTH) o.status = ST_FULL;
            else begin
               shadow_count++;
               heap_mem[shadow_count] = KEY_MIN;
               raise_slot(shadow_count, k, d);
            end
         end
         REQ_EXTRACT: begin
            if (shadow_count == 0) o.status = ST_EMPTY;
            else begin
               o.max_key = heap_mem[1];
               heap_mem[1] = heap_mem[shadow_count];
               shadow_count--;
               sink_root(d);
            end
         end
         REQ_INCKEY: begin
            if (pos == 0 || pos > shadow_count) o.status = ST_BADPOS;
            else raise_slot(pos, k, d);
         end
         default: ;
      endcase
      o.count = shadow_count[6:0];
      return o;
   endfunction

   // stimulus builders; gen_count follows the element count
   task automatic add_req(logic [1:0] rt, logic signed [31:0] k, logic [6:0] p);
      entry_type e;
      e.kind = E_REQ; e.rtype = rt; e.key = k; e.pos = p; e.val = 0;
      stimulus.push_back(e);
      if (rt == REQ_INSERT && gen_count < DEPTH) gen_count++;
      if (rt == REQ_EXTRACT && gen_count > 0) gen_count--;
   endtask

   task automatic add_ctl(entry_kind_type kd, int v);
      entry_type e;
      e.kind = kd; e.rtype = REQ_INSERT; e.key = '0; e.pos = '0; e.val = v;
      stimulus.push_back(e);
   endtask

   function automatic logic signed [31:0] rand_key();
      case ($urandom_range(9))
         0: return 32'sh7FFFFFFF;
         1: return KEY_MIN;
         2, 3: return $signed(32'($urandom_range(15)) - 32'd8);
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic add_mix(int n);
      int r;
      logic [6:0] p;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 40) add_req(REQ_INSERT, rand_key(), 7'($urandom));
         else if (r < 70) add_req(REQ_EXTRACT, rand_key(), 7'($urandom));
         else if (r < 95) begin
            if (gen_count > 0 && $urandom_range(4) != 0)
               p = 7'($urandom_range(gen_count, 1));
            else
               p = 7'($urandom);
            add_req(REQ_INCKEY, rand_key(), p);
         end else add_req(REQ_UNKNOWN, rand_key(), 7'($urandom));
      end
   endtask

   task automatic add_fill_and_empty();
      while (gen_count < DEPTH) add_req(REQ_INSERT, rand_key(), 7'($urandom));
      repeat (3) add_req(REQ_INSERT, rand_key(), 7'($urandom));
      add_req(REQ_INCKEY, rand_key(), 7'd64);
      add_req(REQ_INCKEY, rand_key(), 7'd65);
      while (gen_count > 0) add_req(REQ_EXTRACT, '0, '0);
      add_req(REQ_EXTRACT, '0, '0);
   endtask

   // stimulus plan
   initial begin
      int arities[8] = '{3, 4, 0, 7, 1, 5, 6, 2};
      int gaps[4] = '{0, 46, 0, 37};
      // directed opening at reset arity
      add_req(REQ_EXTRACT, '0, '0);
      add_req(REQ_INCKEY, 32'sd5, 7'd0);
      add_req(REQ_INSERT, 32'sh7FFFFFFF, 7'd0);
      add_req(REQ_INSERT, KEY_MIN, 7'd0);
      add_req(REQ_INSERT, 32'sd0, 7'd0);
      add_req(REQ_INSERT, -32'sd1, 7'd0);
      add_req(REQ_INCKEY, 32'sd7, 7'd1);
      add_req(REQ_INCKEY, 32'sd100, 7'd3);
      add_req(REQ_INCKEY, 32'sh7FFFFFFF, 7'd4);
      add_req(REQ_INCKEY, 32'sd1, 7'd5);
      add_req(REQ_INCKEY, 32'sd1, 7'd127);
      add_req(REQ_UNKNOWN, -32'sd1, 7'h7F);
      repeat (5) add_req(REQ_EXTRACT, '0, '0);
      add_mix(40);
      for (int i = 0; i < 8; i++) begin
         add_ctl(E_DRAIN, 0);
         add_ctl(E_ARITY, arities[i]);
         add_ctl(E_GAPS, gaps[i % 4]);
         add_mix(15);
         if (i == 1 || i == 5) add_fill_and_empty();
         add_mix(15);
         // keep the heap well populated for a while
         repeat (10) add_req(REQ_INSERT, rand_key(), 7'($urandom));
         add_mix(10);
      end
      stim_done = 1;
   end

   // driver: changes inputs on the falling edge
   always @(negedge clock) begin
      logic nstart, nwr;
      nstart = 1'b0;
      nwr = 1'b0;
      if (reset) begin
         nstart = 1'b0;
      end else if (start && taken != issued) begin
         nstart = 1'b1;
      end else if (stimulus.size() != 0) begin
         case (stimulus[0].kind)
            E_GAPS: begin
               gap_pct = stimulus[0].val;
               void'(stimulus.pop_front());
            end
            E_DRAIN: begin
               if (pending_outcomes.size() != 0) settle_cnt = 0;
               else if (settle_cnt < SETTLE) settle_cnt++;
               else begin
                  settle_cnt = 0;
                  void'(stimulus.pop_front());
               end
            end
            E_ARITY: begin
               nwr = 1'b1;
               csr_arity <= 3'(stimulus[0].val);
               void'(stimulus.pop_front());
            end
            default: begin
               if ($urandom_range(99) >= gap_pct) begin
                  nstart = 1'b1;
                  req_type <= stimulus[0].rtype;
                  req_key <= stimulus[0].key;
                  req_position <= stimulus[0].pos;
                  issued++;
                  void'(stimulus.pop_front());
               end
            end
         endcase
      end
      start <= nstart;
      csr_wr_en <= nwr;
   end

   // monitor: samples on the rising edge
   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_outcomes.size() == 0) begin
               $error("unexpected transaction: max_key %0d status %0d count %0d",
                      rsp_max_key, rsp_status, rsp_count);
               failed = 1;
            end else begin
               exp_o = pending_outcomes.pop_front();
               if (rsp_max_key !== exp_o.max_key) begin
                  $error("max_key: expected %0d, got %0d", exp_o.max_key, rsp_max_key);
                  failed = 1;
               end
               if (rsp_status !== exp_o.status) begin
                  $error("status: expected %0d, got %0d", exp_o.status, rsp_status);
                  failed = 1;
               end
               if (rsp_count !== exp_o.count) begin
                  $error("count: expected %0d, got %0d", exp_o.count, rsp_count);
                  failed = 1;
               end
            end
         end
         if (csr_wr_en) arity_reg = csr_arity;
         if (start && !busy) begin
            pending_outcomes.push_back(heap_request(req_type, req_key, req_position));
            taken++;
         end
      end
   end

   // reset, then wait for the traffic to finish
   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (stim_done && stimulus.size() == 0 && taken == issued);
      wait (pending_outcomes.size() == 0);
      repeat (60) @(posedge clock);
      if (!failed && pending_outcomes.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/dapq_pkg.sv
rtl/dapq_ram.sv
rtl/d_ary_max_priority_queue.sv
test/d_ary_max_priority_queue_tb.sv
